// ===== design/birle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// birle_pkg
// Shared types and constants of the binary image run-length encoder.
// ----------------------------------------------------------------------------
package birle_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W   = 8;
   localparam int COL_W   = 12;
   localparam int ROW_W   = 12;
   localparam int LEN_W   = 13;
   localparam int SIZE_W  = 13;
   localparam int CNT_W   = 25;
   localparam int CSR_W   = 13;
   localparam int IDX_W   = 2;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [SIZE_W-1:0] WIDTH_MAX = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);

   localparam logic [IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [IDX_W-1:0] CSR_BIT_MASK = 2'd1;
   localparam logic [IDX_W-1:0] CSR_WIDTH    = 2'd2;
   localparam logic [IDX_W-1:0] CSR_HEIGHT   = 2'd3;

   typedef enum logic [1:0] {
      MODE_NONZERO = 2'd0,
      MODE_ZERO    = 2'd1,
      MODE_MASKED  = 2'd2,
      MODE_BITS    = 2'd3
   } mode_type;

   localparam logic KIND_RUN = 1'b0;
   localparam logic KIND_ROW = 1'b1;

   typedef struct packed {
      mode_type          mode;
      logic [PIX_W-1:0]  bit_mask;
      logic [COL_W-1:0]  last_col;
      logic [ROW_W-1:0]  last_row;
   } cfg_type;

   typedef struct packed {
      logic              record_kind;
      logic [COL_W-1:0]  run_start;
      logic [LEN_W-1:0]  run_length;
      logic [ROW_W-1:0]  row;
      logic [CNT_W-1:0]  table_offset;
      logic [CNT_W-1:0]  pixel_total;
      logic              frame_end;
      logic              last;
   } rec_type;

   typedef struct packed {
      logic [1:0] n;
      rec_type    rec0;
      rec_type    rec1;
   } push_type;

endpackage
`default_nettype wire

// ===== design/birle_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// birle_csr
// Configuration registers and clamping of the frame size to its legal range.
// ----------------------------------------------------------------------------
module birle_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [birle_pkg::IDX_W-1:0] csr_index,
   input  wire logic [birle_pkg::CSR_W-1:0] csr_wdata,
   output birle_pkg::cfg_type              cfg
);
   import birle_pkg::*;

   mode_type          mode_ff,   mode_in;
   logic [PIX_W-1:0]  mask_ff,   mask_in;
   logic [SIZE_W-1:0] width_ff,  width_in;
   logic [SIZE_W-1:0] height_ff, height_in;

   always_comb begin
      mode_in   = mode_ff;
      mask_in   = mask_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:     mode_in   = mode_type'(csr_wdata[1:0]);
            CSR_BIT_MASK: mask_in   = csr_wdata[PIX_W-1:0];
            CSR_WIDTH:    width_in  = csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT:   height_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NONZERO;
         mask_ff   <= 8'hFF;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
      end else begin
         mode_ff   <= mode_in;
         mask_ff   <= mask_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      cfg.mode     = mode_ff;
      cfg.bit_mask = mask_ff;
      if (width_ff == '0)
         cfg.last_col = '0;
      else if (width_ff >= WIDTH_MAX)
         cfg.last_col = COL_W'(WIDTH_MAX - 13'd1);
      else
         cfg.last_col = COL_W'(width_ff - 13'd1);
      if (height_ff == '0)
         cfg.last_row = '0;
      else if (height_ff >= HEIGHT_MAX)
         cfg.last_row = ROW_W'(HEIGHT_MAX - 13'd1);
      else
         cfg.last_row = ROW_W'(height_ff - 13'd1);
   end

endmodule
`default_nettype wire

// ===== design/birle_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// birle_core
// Input register, pixel classification, run tracking and record generation.
// ----------------------------------------------------------------------------
module birle_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire birle_pkg::cfg_type         cfg,
   input  wire logic                       in_valid,
   output      logic                       in_ready,
   input  wire logic [birle_pkg::PIX_W-1:0] in_pixel,
   input  wire logic [birle_pkg::PIX_W-1:0] in_mask,
   input  wire logic                       room,
   output birle_pkg::push_type             push
);
   import birle_pkg::*;

   logic              valid_ff,  valid_in;
   logic [PIX_W-1:0]  pixel_ff,  mask_ff;
   logic              in_run_ff, in_run_in;
   logic [COL_W-1:0]  begin_ff,  begin_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROW_W-1:0]  row_ff,    row_in;
   logic [CNT_W-1:0]  words_ff,  words_in;
   logic [CNT_W-1:0]  fgcnt_ff,  fgcnt_in;

   logic              advance;
   logic              fg;
   logic              row_end;
   logic              fend;
   logic              close_bg;
   logic              close_end;
   logic              closing;
   logic [COL_W-1:0]  begin_eff;
   logic [LEN_W-1:0]  run_len;
   logic [CNT_W-1:0]  fg_new;
   logic [CNT_W-1:0]  words_new;
   logic [CNT_W:0]    fg_sum;
   logic [CNT_W:0]    words_sum;
   rec_type           run_rec;
   rec_type           row_rec;

   assign advance  = valid_ff && room;
   assign in_ready = !valid_ff || room;

   always_comb begin
      case (cfg.mode)
         MODE_NONZERO: fg = pixel_ff != '0;
         MODE_ZERO:    fg = pixel_ff == '0;
         MODE_MASKED:  fg = (pixel_ff != '0) && (mask_ff != '0);
         MODE_BITS:    fg = (pixel_ff & cfg.bit_mask) != '0;
         default:      fg = 1'b0;
      endcase

      row_end   = column_ff >= cfg.last_col;
      fend      = row_ff >= cfg.last_row;
      close_bg  = !fg && in_run_ff;
      close_end = fg && row_end;
      closing   = close_bg || close_end;
      begin_eff = (fg && !in_run_ff) ? column_ff : begin_ff;

      if (close_bg)
         run_len = LEN_W'({1'b0, column_ff} - {1'b0, begin_eff});
      else
         run_len = LEN_W'({1'b0, column_ff} + 13'd1 - {1'b0, begin_eff});

      fg_sum    = {1'b0, fgcnt_ff} + 26'd1;
      words_sum = {1'b0, words_ff} + 26'd2;
      if (!fg)
         fg_new = fgcnt_ff;
      else if (fg_sum > {1'b0, CNT_MAX})
         fg_new = CNT_MAX;
      else
         fg_new = fg_sum[CNT_W-1:0];
      if (!closing)
         words_new = words_ff;
      else if (words_sum > {1'b0, CNT_MAX})
         words_new = CNT_MAX;
      else
         words_new = words_sum[CNT_W-1:0];

      run_rec.record_kind  = KIND_RUN;
      run_rec.run_start    = begin_eff;
      run_rec.run_length   = run_len;
      run_rec.row          = row_ff;
      run_rec.table_offset = words_new;
      run_rec.pixel_total  = fg_new;
      run_rec.frame_end    = 1'b0;
      run_rec.last         = !row_end;

      row_rec.record_kind  = KIND_ROW;
      row_rec.run_start    = '0;
      row_rec.run_length   = '0;
      row_rec.row          = row_ff;
      row_rec.table_offset = words_new;
      row_rec.pixel_total  = fg_new;
      row_rec.frame_end    = fend;
      row_rec.last         = 1'b1;

      push.n    = advance ? ({1'b0, closing} + {1'b0, row_end}) : 2'd0;
      push.rec0 = closing ? run_rec : row_rec;
      push.rec1 = row_rec;
   end

   always_comb begin
      in_run_in = in_run_ff;
      begin_in  = begin_ff;
      column_in = column_ff;
      row_in    = row_ff;
      words_in  = words_ff;
      fgcnt_in  = fgcnt_ff;
      if (advance) begin
         in_run_in = fg && !row_end;
         begin_in  = begin_eff;
         words_in  = words_new;
         fgcnt_in  = fg_new;
         if (row_end) begin
            column_in = '0;
            if (fend) begin
               row_in   = '0;
               words_in = '0;
               fgcnt_in = '0;
            end else begin
               row_in = row_ff + 12'd1;
            end
         end else begin
            column_in = column_ff + 12'd1;
         end
      end
      if (in_valid && in_ready)
         valid_in = 1'b1;
      else if (advance)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         in_run_ff <= 1'b0;
         begin_ff  <= '0;
         column_ff <= '0;
         row_ff    <= '0;
         words_ff  <= '0;
         fgcnt_ff  <= '0;
      end else begin
         valid_ff  <= valid_in;
         in_run_ff <= in_run_in;
         begin_ff  <= begin_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         words_ff  <= words_in;
         fgcnt_ff  <= fgcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pixel_ff <= in_pixel;
         mask_ff  <= in_mask;
      end
   end

endmodule
`default_nettype wire

// ===== design/birle_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// birle_queue
// Four-entry record queue; takes up to two records a cycle, gives one.
// ----------------------------------------------------------------------------
module birle_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire birle_pkg::push_type push,
   output      logic                room,
   output      logic                out_valid,
   input  wire logic                out_ready,
   output birle_pkg::rec_type       out_rec
);
   import birle_pkg::*;

   rec_type            ent_ff [QDEPTH];
   logic [QPTR_W-1:0]  head_ff,  head_in;
   logic [QPTR_W-1:0]  tail_ff,  tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;
   logic [QPTR_W-1:0]  tail_next;

   assign room      = count_ff <= QCNT_W'(QDEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_rec   = ent_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign tail_next = tail_ff + 2'd1;

   always_comb begin
      head_in  = pop ? head_ff + 2'd1 : head_ff;
      tail_in  = tail_ff + push.n;
      count_in = count_ff + {1'b0, push.n} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0)
         ent_ff[tail_ff] <= push.rec0;
      if (push.n == 2'd2)
         ent_ff[tail_next] <= push.rec1;
   end

endmodule
`default_nettype wire

// ===== design/binary_image_run_length_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// binary_image_run_length_encoder
// Run-length encoder for a raster stream of 8-bit pixels.
//
// req_ takes one pixel beat (pixel, mask pixel) per cycle in raster order while req_tready is high.
// rsp_ gives run records (start column, length) and one row record at each
// row end, with the run-table offset and the running foreground count.
// tuser[0] is the record kind, tuser[1] marks the final row of the frame,
// tlast marks the last record caused by one pixel.
// Path: a pixel beat is registered in the core, then its records are queued.
// Throughput: one pixel per cycle while the queue has room; a pixel that
// closes a run at row end yields two records, which leave through the
// single output beat per cycle behind a four-record queue.
// csr_ writes mode, bit mask, width and height; write them between frames.
// Reset clears the run state, counters and queue and restores the default
// configuration. When rsp_tready is low the queue fills and req_tready
// drops once fewer than two free entries remain and a pixel waits in the core.
// ----------------------------------------------------------------------------
module binary_image_run_length_encoder (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [15:0]                req_tdata,  // pixel, mask_pixel
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [87:0]                rsp_tdata,  // run_start, run_length,
                                                       // row, table_offset,
                                                       // pixel_total, pad
   output      logic [1:0]                 rsp_tuser,  // record_kind, frame_end
   output      logic                       rsp_tlast,
   input  wire logic                       csr_wr_en,
   input  wire logic [birle_pkg::IDX_W-1:0] csr_index,
   input  wire logic [birle_pkg::CSR_W-1:0] csr_wdata
);
   import birle_pkg::*;

   cfg_type  cfg;
   push_type push;
   rec_type  rec;
   logic     room;

   birle_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   birle_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_pixel (req_tdata[7:0]),
      .in_mask  (req_tdata[15:8]),
      .room     (room),
      .push     (push)
   );

   birle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (rec)
   );

   assign rsp_tdata = {1'b0, rec.pixel_total, rec.table_offset, rec.row,
                       rec.run_length, rec.run_start};
   assign rsp_tuser = {rec.frame_end, rec.record_kind};
   assign rsp_tlast = rec.last;

`ifndef ASSERT_OFF
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.n != 2'd0) |-> room)
      else $error("records pushed without queue room");

   a_row_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("row record not marked last");

   a_row_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[24:0] == 25'd0))
      else $error("row record carries run data");

   a_fend_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("frame end on a run record");
`endif

endmodule
`default_nettype wire

// ===== bench/rle_record_checker.sv =====
// ----------------------------------------------------------------------------
// rle_record_checker
// Watches the pixel, record and register ports of the run-length encoder.
// Keeps its own copy of the configuration and run state, works out the
// records each accepted pixel beat must cause, and compares every record
// beat field by field against the oldest record still due.
// ----------------------------------------------------------------------------
module rle_record_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [15:0]                 req_tdata,  // pixel, mask_pixel
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [87:0]                 rsp_tdata,  // run_start, run_length,
                                                        // row, table_offset,
                                                        // pixel_total, pad
   input  wire logic [1:0]                  rsp_tuser,  // record_kind, frame_end
   input  wire logic                        rsp_tlast,
   input  wire logic                        csr_wr_en,
   input  wire logic [birle_pkg::IDX_W-1:0] csr_index,
   input  wire logic [birle_pkg::CSR_W-1:0] csr_wdata,
   output int                               mismatches,
   output int                               due_count,
   output int                               records_seen,
   output int                               frames_seen
);

   import birle_pkg::*;

   mode_type          cur_mode;
   logic [PIX_W-1:0]  cur_mask;
   logic [SIZE_W-1:0] cur_width;
   logic [SIZE_W-1:0] cur_height;

   logic              open_run;
   logic [COL_W-1:0]  run_first;
   logic [COL_W-1:0]  col_pos;
   logic [ROW_W-1:0]  row_pos;
   logic [CNT_W-1:0]  words;
   logic [CNT_W-1:0]  fg_pixels;

   rec_type           due_records [$];

   initial begin
      mismatches   = 0;
      due_count    = 0;
      records_seen = 0;
      frames_seen  = 0;
   end

   function automatic logic [SIZE_W-1:0] usable_size(logic [SIZE_W-1:0] v,
                                                     logic [SIZE_W-1:0] lim);
      if (v == '0) return SIZE_W'(1);
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic logic [CNT_W-1:0] add_sat(logic [CNT_W-1:0] a, int unsigned b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + (CNT_W+1)'(b);
      return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic rec_type make_record(logic kind, logic [COL_W-1:0] start,
                                           logic [LEN_W-1:0] len, logic fend);
      rec_type r;
      r.record_kind  = kind;
      r.run_start    = start;
      r.run_length   = len;
      r.row          = row_pos;
      r.table_offset = words;
      r.pixel_total  = fg_pixels;
      r.frame_end    = fend;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic encode_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] msk);
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic              fg;
      logic              row_end;
      logic              fend;
      rec_type           made [2];
      int                n;
      n = 0;
      w = usable_size(cur_width, WIDTH_MAX);
      h = usable_size(cur_height, HEIGHT_MAX);
      case (cur_mode)
         MODE_NONZERO: fg = (pix != '0);
         MODE_ZERO:    fg = (pix == '0);
         MODE_MASKED:  fg = (pix != '0) && (msk != '0);
         default:      fg = ((pix & cur_mask) != '0);
      endcase
      row_end = ({1'b0, col_pos} >= w - SIZE_W'(1));

      if (fg) begin
         fg_pixels = add_sat(fg_pixels, 1);
         if (!open_run) begin
            open_run  = 1'b1;
            run_first = col_pos;
         end
      end else if (open_run) begin
         words = add_sat(words, 2);
         made[n] = make_record(KIND_RUN, run_first, {1'b0, col_pos} - {1'b0, run_first},
                               1'b0);
         n++;
         open_run = 1'b0;
      end

      if (row_end) begin
         fend = ({1'b0, row_pos} >= h - SIZE_W'(1));
         if (open_run) begin
            words = add_sat(words, 2);
            made[n] = make_record(KIND_RUN, run_first,
                                  {1'b0, col_pos} + LEN_W'(1) - {1'b0, run_first}, 1'b0);
            n++;
            open_run = 1'b0;
         end
         made[n] = make_record(KIND_ROW, '0, '0, fend);
         n++;
         col_pos = '0;
         if (fend) begin
            row_pos   = '0;
            words     = '0;
            fg_pixels = '0;
         end else begin
            row_pos = row_pos + ROW_W'(1);
         end
      end else begin
         col_pos = col_pos + COL_W'(1);
      end

      if (n > 0) made[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) due_records.push_back(made[i]);
   endtask

   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (reset) begin
         cur_mode   = MODE_NONZERO;
         cur_mask   = 8'hFF;
         cur_width  = SIZE_W'(640);
         cur_height = SIZE_W'(480);
         open_run   = 1'b0;
         run_first  = '0;
         col_pos    = '0;
         row_pos    = '0;
         words      = '0;
         fg_pixels  = '0;
         due_records.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE:     cur_mode   = mode_type'(csr_wdata[1:0]);
               CSR_BIT_MASK: cur_mask   = csr_wdata[PIX_W-1:0];
               CSR_WIDTH:    cur_width  = csr_wdata[SIZE_W-1:0];
               CSR_HEIGHT:   cur_height = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.record_kind  = rsp_tuser[0];
            got.frame_end    = rsp_tuser[1];
            got.last         = rsp_tlast;
            got.run_start    = rsp_tdata[11:0];
            got.run_length   = rsp_tdata[24:12];
            got.row          = rsp_tdata[36:25];
            got.table_offset = rsp_tdata[61:37];
            got.pixel_total  = rsp_tdata[86:62];
            records_seen++;
            if (got.frame_end) frames_seen++;
            if (due_records.size() == 0) begin
               $error("record beat with no record due: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = due_records.pop_front();
               check_field("record_kind",  want.record_kind,  got.record_kind);
               check_field("run_start",    want.run_start,    got.run_start);
               check_field("run_length",   want.run_length,   got.run_length);
               check_field("row",          want.row,          got.row);
               check_field("table_offset", want.table_offset, got.table_offset);
               check_field("pixel_total",  want.pixel_total,  got.pixel_total);
               check_field("frame_end",    want.frame_end,    got.frame_end);
               check_field("last",         want.last,         got.last);
            end
         end

         if (req_tvalid && req_tready) encode_pixel(req_tdata[7:0], req_tdata[15:8]);
      end
      due_count <= due_records.size();
   end

endmodule

// ===== bench/tb_binary_image_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_binary_image_run_length_encoder
// Drives pixel beats and register writes into the run-length encoder and
// stalls the record channel at random. A short directed sequence covers runs
// closed by background and at row end, every foreground mode, sizes of zero
// and size changes in the middle of a frame; stretches at and above the
// largest row length and frame height and random phases with varied
// settings and pixel densities follow. The checker judges every record.
// ----------------------------------------------------------------------------
module tb_binary_image_run_length_encoder;

   import birle_pkg::*;

   localparam int RANDOM_PIXELS = 1100;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [87:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;
   logic              csr_wr_en  = 1'b0;
   logic [IDX_W-1:0]  csr_index  = CSR_MODE;
   logic [CSR_W-1:0]  csr_wdata  = '0;

   logic              quiet      = 1'b0;
   int                hold_off   = 0;
   int                pixels_sent = 0;
   int                phases     = 0;

   int                mismatches;
   int                due_count;
   int                records_seen;
   int                frames_seen;

   binary_image_run_length_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rle_record_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .due_count    (due_count),
      .records_seen (records_seen),
      .frames_seen  (frames_seen)
   );

   always #4 clock = ~clock;

   function automatic int idle_len();
      if ($urandom_range(0, 15) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] pick_value(int dens);
      if ($urandom_range(0, 99) < dens) return 8'($urandom_range(1, 255));
      return 8'h00;
   endfunction

   // stall the record channel
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         hold_off   <= 0;
      end else if (hold_off > 1) begin
         rsp_tready <= 1'b0;
         hold_off   <= hold_off - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         hold_off   <= idle_len();
      end else begin
         rsp_tready <= 1'b1;
         hold_off   <= 0;
      end
   end

   task automatic send_pixel(input logic [7:0] pix, input logic [7:0] msk);
      int gap;
      gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {msk, pix};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input mode_type m, input logic [7:0] bm,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= CSR_W'(m);
      @(posedge clock);
      csr_index <= CSR_BIT_MASK;
      csr_wdata <= CSR_W'(bm);
      @(posedge clock);
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      phases++;
   endtask

   initial begin
      int               burst;
      int               dens;
      int               mask_dens;
      int               random_pixels;
      mode_type         m;
      logic [7:0]       bm;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;

      random_pixels = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // run closed by background, run closed at row end, empty row at frame end
      set_config(MODE_NONZERO, 8'hFF, 13'd4, 13'd2);
      send_pixel(8'hFF, 8'h00);
      send_pixel(8'h00, 8'hFF);
      send_pixel(8'h80, 8'h00);
      send_pixel(8'h01, 8'h00);
      repeat (4) send_pixel(8'h00, 8'h00);
      wait_idle();

      set_config(MODE_ZERO, 8'hFF, 13'd3, 13'd1);
      repeat (3) send_pixel(8'h00, 8'h55);
      send_pixel(8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00);
      send_pixel(8'hFF, 8'hAA);
      wait_idle();

      set_config(MODE_MASKED, 8'h00, 13'd2, 13'd1);
      send_pixel(8'h05, 8'h00);
      send_pixel(8'h05, 8'hFF);
      send_pixel(8'h00, 8'hFF);
      send_pixel(8'hFF, 8'h80);
      wait_idle();

      // zero sizes act as one
      set_config(MODE_BITS, 8'h0F, 13'd0, 13'd0);
      send_pixel(8'hF0, 8'hFF);
      send_pixel(8'h01, 8'h00);
      wait_idle();

      // shrink width and height in the middle of a frame
      set_config(MODE_NONZERO, 8'hFF, 13'd6, 13'd3);
      repeat (4) send_pixel(8'h11, 8'h00);
      wait_idle();
      set_config(MODE_NONZERO, 8'hFF, 13'd2, 13'd3);
      send_pixel(8'h22, 8'h00);
      wait_idle();
      set_config(MODE_BITS, 8'h80, 13'd2, 13'd1);
      send_pixel(8'h80, 8'h00);
      send_pixel(8'h7F, 8'hFF);
      wait_idle();

      // widest row, only its start sent
      set_config(MODE_NONZERO, 8'hFF, 13'd4096, 13'd2);
      repeat (60) send_pixel(pick_value(50), pick_value(50));
      wait_idle();

      // width above the maximum, all foreground
      quiet <= ($urandom_range(0, 1) == 0);
      set_config(MODE_ZERO, 8'hFF, 13'h1FFF, 13'd4096);
      repeat (300) send_pixel(8'h00, pick_value(50));
      wait_idle();

      // tallest frame, one pixel per row
      quiet <= 1'b0;
      set_config(mode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 13'd0, 13'h1FFF);
      repeat (300) send_pixel(pick_value(50), pick_value(50));
      wait_idle();

      while (random_pixels < RANDOM_PIXELS) begin
         m = mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:       bm = 8'h00;
            1:       bm = 8'hFF;
            default: bm = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = SIZE_W'($urandom_range(9, 40));
            default: w = SIZE_W'($urandom_range(1, 8));
         endcase
         h = ($urandom_range(0, 9) == 0) ? '0 : SIZE_W'($urandom_range(1, 4));
         quiet <= ($urandom_range(0, 3) == 0);
         set_config(m, bm, w, h);
         dens      = $urandom_range(0, 4) * 25;
         mask_dens = $urandom_range(0, 4) * 25;
         burst     = $urandom_range(5, 90);
         repeat (burst) send_pixel(pick_value(dens), pick_value(mask_dens));
         random_pixels += burst;
         wait_idle();
      end

      $display("%0d pixel beats under %0d register settings, all four modes",
               pixels_sent, phases);
      $display("%0d record beats checked, %0d frames closed", records_seen, frames_seen);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
